[rtl/mac_child_table_top_assert.svh]
// Assertion macros for the MAC child table RTL.
// Included by mct_core, which checks its own sequencing; no other dependencies.
`ifndef MAC_CHILD_TABLE_TOP_ASSERT_SVH
`define MAC_CHILD_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCT_ASSERT_HOLD(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mct_pkg.sv]
// Package for the MAC child table: sizes, request and status codes, and the
// control structures passed between the sequencer and the compare unit.
package mct_pkg;

    localparam int MAC_BYTES    = 6;
    localparam int TABLE_DEPTH  = 64;
    localparam int ID_BITS      = 16;
    localparam int SLOT_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CTR_BITS     = ID_BITS - 2;
    localparam int KEY_W        = MAC_BYTES * 8;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int ID_OUT_W     = 16;
    localparam int ENTRY_ID_W   = 16;
    localparam int CNT_W        = 7;
    localparam int LIMIT_W      = 7;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);
    localparam logic [APB_ADDR_W-3:0] REG_CHILD_LIMIT = '0;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD          = 2'd0,
        KIND_REMOVE       = 2'd1,
        KIND_CHILD_ADD    = 2'd2,
        KIND_CHILD_REMOVE = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EXISTS    = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic              start;
        logic              cmp_vld;
        logic [SLOT_W-1:0] cmp_slot;
        logic              slot_vld;
    } t_scan_ctl;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  hit_slot;
        logic [ID_BITS-1:0] hit_id;
        logic               free_found;
        logic [SLOT_W-1:0]  free_slot;
    } t_scan_res;

endpackage

[rtl/mct_if.sv]
// Request and response channel interfaces for the MAC child table.
// Depends on mct_pkg for the field widths.
interface mct_req_if import mct_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [KEY_W-1:0]      mac;
    logic [ENTRY_ID_W-1:0] entry_id;

    modport source (output valid, output kind, output mac, output entry_id, input ready);
    modport sink (input valid, input kind, input mac, input entry_id, output ready);
endinterface

interface mct_rsp_if import mct_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_OUT_W-1:0] id_out;

    modport source (output valid, output status, output id_out, input ready);
    modport sink (input valid, input status, input id_out, output ready);
endinterface

[rtl/mac_child_table_top.sv]
// Top level of the MAC child table: APB register slave plus table sequencer.
// Depends on mct_pkg, mct_if, mct_apb and mct_core.
//
// Exact-match table of up to 64 MAC keys with a 16-bit id each. Every request
// beat scans all 64 slots through one shared key comparator, one slot per
// cycle out of a registered memory read. After acceptance the sequencer steps
// through the scan, a step that finishes the last compare and a decide step that
// loads the response, waiting while the response register is still held by
// back-pressure. A finished response waits in its own register, so the next
// request is taken while it is pending. The table is empty after reset with no
// clearing pass; child_limit sits at byte address 0.
module mac_child_table_top import mct_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mct_req_if.sink               i_req,
    mct_rsp_if.source             o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [LIMIT_W-1:0] child_limit;

    mct_apb u_apb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_child_limit (child_limit)
    );

    mct_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .i_child_limit (child_limit)
    );

endmodule

[rtl/mct_apb.sv]
// APB register slave for the MAC child table; holds the child_limit register.
// Depends on mct_pkg for the address map and reset value.
module mct_apb import mct_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [LIMIT_W-1:0]    o_child_limit
);

    logic [LIMIT_W-1:0] r_child_limit;
    logic               reg_sel;
    logic               wr_en;

    assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_CHILD_LIMIT);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? APB_DATA_W'(r_child_limit) : '0;
    assign o_child_limit = r_child_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_child_limit <= LIMIT_RESET;
        end else if (wr_en && reg_sel) begin
            r_child_limit <= pwdata[LIMIT_W-1:0];
        end
    end

endmodule

[rtl/mct_cmp.sv]
// Shared key compare unit: checks one table slot per beat of the scan and
// keeps the first matching slot and the lowest free slot. Depends on mct_pkg.
module mct_cmp import mct_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_scan_ctl          i_ctl,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [KEY_W-1:0]   i_rd_key,
    input  logic [ID_BITS-1:0] i_rd_id,
    output t_scan_res          o_res
);

    t_scan_res r_res;
    logic      key_eq;

    assign key_eq = (i_rd_key == i_key);
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else if (i_ctl.start) begin
            r_res.hit        <= 1'b0;
            r_res.free_found <= 1'b0;
        end else if (i_ctl.cmp_vld) begin
            if (i_ctl.slot_vld && key_eq && !r_res.hit) begin
                r_res.hit      <= 1'b1;
                r_res.hit_slot <= i_ctl.cmp_slot;
                r_res.hit_id   <= i_rd_id;
            end
            if (!i_ctl.slot_vld && !r_res.free_found) begin
                r_res.free_found <= 1'b1;
                r_res.free_slot  <= i_ctl.cmp_slot;
            end
        end
    end

endmodule

[rtl/mct_core.sv]
// Table sequencer: key/id memory, slot valid bits, entry count and id counter.
// Depends on mct_pkg, mct_if, mct_cmp and mac_child_table_top_assert.svh.
module mct_core import mct_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mct_req_if.sink            i_req,
    mct_rsp_if.source          o_rsp,
    input  logic [LIMIT_W-1:0] i_child_limit
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_DECIDE = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    t_kind                    r_kind, n_kind;
    logic [KEY_W-1:0]         r_key, n_key;
    logic [ID_BITS-1:0]       r_eid, n_eid;
    logic [SLOT_W-1:0]        r_addr, n_addr;
    logic                     r_cmp_vld;
    logic [SLOT_W-1:0]        r_cmp_slot;
    logic [TABLE_DEPTH-1:0]   r_valid, n_valid;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CTR_BITS-1:0]      r_ctr, n_ctr;
    logic                     r_out_valid, n_out_valid;
    t_status                  r_out_status, n_out_status;
    logic [ID_OUT_W-1:0]      r_out_id, n_out_id;

    logic [KEY_W-1:0]         r_mem_key [TABLE_DEPTH];
    logic [ID_BITS-1:0]       r_mem_id [TABLE_DEPTH];
    logic [KEY_W-1:0]         r_rd_key;
    logic [ID_BITS-1:0]       r_rd_id;

    logic                     accept;
    logic                     out_free;
    logic                     over_limit;
    logic                     mem_we;
    t_scan_ctl                scan_ctl;
    t_scan_res                scan_res;

    assign i_req.ready  = (r_state == ST_IDLE);
    assign accept       = i_req.valid && i_req.ready;
    assign out_free     = !r_out_valid || o_rsp.ready;
    assign over_limit   = ((CNT_W + 1)'(r_count) + (CNT_W + 1)'(1)) > (CNT_W + 1)'(i_child_limit);

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.id_out = r_out_id;

    assign scan_ctl.start    = accept;
    assign scan_ctl.cmp_vld  = r_cmp_vld;
    assign scan_ctl.cmp_slot = r_cmp_slot;
    assign scan_ctl.slot_vld = r_valid[r_cmp_slot];

    mct_cmp u_cmp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (scan_ctl),
        .i_key    (r_key),
        .i_rd_key (r_rd_key),
        .i_rd_id  (r_rd_id),
        .o_res    (scan_res)
    );

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_key        = r_key;
        n_eid        = r_eid;
        n_addr       = r_addr;
        n_valid      = r_valid;
        n_count      = r_count;
        n_ctr        = r_ctr;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        mem_we       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_kind  = t_kind'(i_req.kind);
                    n_key   = i_req.mac;
                    n_eid   = i_req.entry_id[ID_BITS-1:0];
                    n_addr  = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_addr == SLOT_W'(TABLE_DEPTH - 1)) begin
                    n_state = ST_LAST;
                end else begin
                    n_addr = r_addr + SLOT_W'(1);
                end
            end
            ST_LAST: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STATUS_OK;
                    n_out_id     = '0;
                    n_state      = ST_IDLE;
                    case (r_kind)
                        KIND_ADD: begin
                            if (scan_res.hit) begin
                                n_out_status = STATUS_EXISTS;
                            end else if (over_limit || !scan_res.free_found) begin
                                n_out_status = STATUS_FULL;
                            end else begin
                                mem_we                      = 1'b1;
                                n_valid[scan_res.free_slot] = 1'b1;
                                n_count                     = r_count + CNT_W'(1);
                            end
                        end
                        KIND_REMOVE: begin
                            if (!scan_res.hit) begin
                                n_out_status = STATUS_NOT_FOUND;
                            end else begin
                                n_valid[scan_res.hit_slot] = 1'b0;
                                if (r_count != '0) begin
                                    n_count = r_count - CNT_W'(1);
                                end
                            end
                        end
                        KIND_CHILD_ADD: begin
                            if (scan_res.hit) begin
                                n_out_status = STATUS_EXISTS;
                            end else if (over_limit) begin
                                n_out_status = STATUS_FULL;
                            end else begin
                                n_ctr    = r_ctr + CTR_BITS'(1);
                                n_out_id = ID_OUT_W'({1'b1, n_ctr});
                            end
                        end
                        KIND_CHILD_REMOVE: begin
                            if (!scan_res.hit) begin
                                n_out_status = STATUS_NOT_FOUND;
                            end else begin
                                n_out_id = ID_OUT_W'(scan_res.hit_id);
                            end
                        end
                        default: begin
                            n_out_status = STATUS_OK;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmp_vld   <= 1'b0;
            r_valid     <= '0;
            r_count     <= '0;
            r_ctr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_vld   <= (r_state == ST_SCAN);
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_ctr       <= n_ctr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_key        <= n_key;
        r_eid        <= n_eid;
        r_addr       <= n_addr;
        r_cmp_slot   <= r_addr;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_key[scan_res.free_slot] <= r_key;
            r_mem_id[scan_res.free_slot]  <= r_eid;
        end
        r_rd_key <= r_mem_key[r_addr];
        r_rd_id  <= r_mem_id[r_addr];
    end

`include "mac_child_table_top_assert.svh"

    `MCT_ASSERT_HOLD(a_count_matches_valid, i_clk, i_rst_n, 1'b1, r_count == CNT_W'($countones(r_valid)), "entry count disagrees with slot valid bits")
    `MCT_ASSERT_HOLD(a_rsp_from_decide, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == ST_DECIDE), "response loaded outside the decide step")
    `MCT_ASSERT_HOLD(a_id_zero_on_error, i_clk, i_rst_n, r_out_valid && (r_out_status != STATUS_OK), r_out_id == '0, "nonzero id with an error status")
    `MCT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, r_state == ST_SCAN && !i_req.ready, "sequencer did not start the scan")

endmodule

[tb/mac_child_table_top_tb.sv]
// Self-checking testbench for mac_child_table_top: random and directed table requests
// with a built-in table predictor, idle bursts on both channels and APB limit updates.
// Depends on mct_pkg, the mct_req_if/mct_rsp_if interfaces and the RTL top level.
module mac_child_table_top_tb;
    import mct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_kind                 kind;
        logic [KEY_W-1:0]      mac;
        logic [ENTRY_ID_W-1:0] entry_id;
    } t_mac_req;

    typedef struct packed {
        t_status             status;
        logic [ID_OUT_W-1:0] id_out;
    } t_mac_ans;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mct_req_if req_ch();
    mct_rsp_if rsp_ch();

    mac_child_table_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the table, the counters and the limit register.
    logic                 slot_used [TABLE_DEPTH];
    logic [KEY_W-1:0]     slot_key  [TABLE_DEPTH];
    logic [ID_BITS-1:0]   slot_id   [TABLE_DEPTH];
    logic [CNT_W-1:0]     entry_count = '0;
    logic [CTR_BITS-1:0]  id_ctr = '0;
    logic [LIMIT_W-1:0]   limit_shadow = LIMIT_RESET;

    t_mac_req         req_backlog[$];
    t_mac_ans         awaited_answers[$];
    logic [KEY_W-1:0] key_pool[$];
    t_mac_req         next_req;
    t_mac_ans         want;

    int   requests_queued = 0;
    int   answers_seen = 0;
    int   errors = 0;
    int   send_gap = 0;
    int   rsp_stall = 0;
    logic req_taken = 1'b0;
    bit   idle_enabled = 1'b1;

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i] = '0;
            slot_id[i] = '0;
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int find_slot(logic [KEY_W-1:0] mac);
        int hit;
        hit = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_used[i] && slot_key[i] == mac && hit < 0) begin
                hit = i;
            end
        end
        return hit;
    endfunction

    function automatic t_mac_ans apply_table_request(t_mac_req req);
        int       hit;
        int       free_idx;
        bit       over_limit;
        t_mac_ans ans;
        hit = find_slot(req.mac);
        free_idx = -1;
        over_limit = (int'(entry_count) + 1) > int'(limit_shadow);
        ans.status = STATUS_OK;
        ans.id_out = '0;
        case (req.kind)
            KIND_ADD: begin
                if (hit >= 0) begin
                    ans.status = STATUS_EXISTS;
                end else if (over_limit) begin
                    ans.status = STATUS_FULL;
                end else begin
                    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
                        if (!slot_used[i]) begin
                            free_idx = i;
                        end
                    end
                    if (free_idx < 0) begin
                        ans.status = STATUS_FULL;
                    end else begin
                        slot_used[free_idx] = 1'b1;
                        slot_key[free_idx] = req.mac;
                        slot_id[free_idx] = req.entry_id[ID_BITS-1:0];
                        entry_count = entry_count + 1'b1;
                    end
                end
            end
            KIND_REMOVE: begin
                if (hit < 0) begin
                    ans.status = STATUS_NOT_FOUND;
                end else begin
                    slot_used[hit] = 1'b0;
                    if (entry_count != 0) begin
                        entry_count = entry_count - 1'b1;
                    end
                end
            end
            KIND_CHILD_ADD: begin
                if (hit >= 0) begin
                    ans.status = STATUS_EXISTS;
                end else if (over_limit) begin
                    ans.status = STATUS_FULL;
                end else begin
                    id_ctr = id_ctr + 1'b1;
                    ans.id_out = ID_OUT_W'({1'b1, id_ctr});
                end
            end
            default: begin
                if (hit < 0) begin
                    ans.status = STATUS_NOT_FOUND;
                end else begin
                    ans.id_out = ID_OUT_W'(slot_id[hit]);
                end
            end
        endcase
        return ans;
    endfunction

    // Request monitor, predictor and response checker.
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            answers_seen++;
            if (awaited_answers.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual status %0d id %h",
                         $time, rsp_ch.status, rsp_ch.id_out);
                errors++;
            end else begin
                want = awaited_answers.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.id_out !== want.id_out) begin
                    $display("%0t: id_out mismatch, expected %h actual %h",
                             $time, want.id_out, rsp_ch.id_out);
                    errors++;
                end
            end
        end
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            awaited_answers.push_back(apply_table_request('{kind: t_kind'(req_ch.kind),
                                                            mac: req_ch.mac,
                                                            entry_id: req_ch.entry_id}));
        end
    end

    // Request driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_taken) begin
            if (send_gap != 0) begin
                req_ch.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (req_backlog.size() != 0) begin
                next_req = req_backlog.pop_front();
                req_ch.kind <= next_req.kind;
                req_ch.mac <= next_req.mac;
                req_ch.entry_id <= next_req.entry_id;
                req_ch.valid <= 1'b1;
                if (idle_enabled && $urandom_range(0, 5) == 0) begin
                    send_gap <= $urandom_range(1, 10);
                end
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response back-pressure.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_stall != 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
        end else begin
            rsp_ch.ready <= 1'b1;
            if (idle_enabled && $urandom_range(0, 7) == 0) begin
                rsp_stall <= $urandom_range(1, 10);
            end
        end
    end

    function automatic logic [KEY_W-1:0] random_mac();
        return KEY_W'({$urandom, $urandom});
    endfunction

    task automatic queue_request(t_kind kind, logic [KEY_W-1:0] mac,
                                 logic [ENTRY_ID_W-1:0] entry_id);
        req_backlog.push_back('{kind: kind, mac: mac, entry_id: entry_id});
        requests_queued++;
    endtask

    task automatic wait_for_answers();
        while (answers_seen != requests_queued) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_child_limit(logic [LIMIT_W-1:0] value);
        wait_for_answers();
        repeat (4) @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_CHILD_LIMIT, 2'b00};
        pwdata <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        limit_shadow = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Fills every free slot, then probes the table with no slot left.
    task automatic fill_table();
        logic [KEY_W-1:0] mac;
        int               free_slots;
        free_slots = TABLE_DEPTH - int'(entry_count);
        repeat (free_slots) begin
            do mac = random_mac(); while (find_slot(mac) >= 0);
            queue_request(KIND_ADD, mac, ENTRY_ID_W'($urandom));
        end
        queue_request(KIND_ADD, random_mac(), ENTRY_ID_W'($urandom));
        queue_request(KIND_CHILD_ADD, random_mac(), '0);
        queue_request(KIND_CHILD_REMOVE, mac, '0);
        queue_request(KIND_ADD, mac, '0);
    endtask

    task automatic run_random_phase(logic [LIMIT_W-1:0] limit, int count);
        int               pick;
        t_kind            kind;
        logic [KEY_W-1:0] mac;
        set_child_limit(limit);
        key_pool.delete();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_used[i]) begin
                key_pool.push_back(slot_key[i]);
            end
        end
        repeat ($urandom_range(4, 20)) key_pool.push_back(random_mac());
        repeat (count) begin
            pick = $urandom_range(0, 99);
            kind = (pick < 35) ? KIND_ADD :
                   (pick < 60) ? KIND_REMOVE :
                   (pick < 80) ? KIND_CHILD_ADD : KIND_CHILD_REMOVE;
            if ($urandom_range(0, 9) == 0) begin
                mac = random_mac();
            end else begin
                mac = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end
            queue_request(kind, mac, ENTRY_ID_W'($urandom));
        end
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_ADD;
        req_ch.mac = '0;
        req_ch.entry_id = '0;
        rsp_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default limit: every operation, key and id extremes, the empty-count remove.
        queue_request(KIND_ADD, '0, '0);
        queue_request(KIND_ADD, '1, '1);
        queue_request(KIND_ADD, '0, 16'h1234);
        queue_request(KIND_CHILD_ADD, '0, '0);
        queue_request(KIND_CHILD_ADD, 48'h0000_0000_0001, '1);
        queue_request(KIND_CHILD_REMOVE, '1, '0);
        queue_request(KIND_CHILD_REMOVE, '0, '1);
        queue_request(KIND_CHILD_REMOVE, 48'h0000_0000_0001, '0);
        queue_request(KIND_REMOVE, 48'h8000_0000_0000, '0);
        queue_request(KIND_REMOVE, '0, '0);
        queue_request(KIND_REMOVE, '0, '0);
        queue_request(KIND_REMOVE, '1, '0);
        queue_request(KIND_REMOVE, '1, '0);

        set_child_limit('0);
        queue_request(KIND_ADD, 48'h0123_4567_89ab, 16'h5a5a);
        queue_request(KIND_CHILD_ADD, 48'h0123_4567_89ab, '0);

        set_child_limit(LIMIT_W'(1));
        queue_request(KIND_ADD, 48'h0123_4567_89ab, 16'ha5a5);
        queue_request(KIND_ADD, 48'hfedc_ba98_7654, 16'h0001);
        queue_request(KIND_CHILD_ADD, 48'h5555_aaaa_5555, '0);
        queue_request(KIND_CHILD_ADD, 48'h0123_4567_89ab, '0);
        queue_request(KIND_CHILD_REMOVE, 48'h0123_4567_89ab, '0);
        queue_request(KIND_REMOVE, 48'h0123_4567_89ab, '0);

        set_child_limit('1);
        fill_table();

        run_random_phase(LIMIT_W'(64), 260);
        run_random_phase(LIMIT_W'($urandom_range(2, 63)), 260);
        run_random_phase(LIMIT_W'(1), 120);
        run_random_phase(LIMIT_W'($urandom_range(2, 20)), 260);
        run_random_phase('1, 260);
        wait_for_answers();
        idle_enabled = 1'b0;
        run_random_phase(LIMIT_RESET, 200);

        wait_for_answers();
        repeat (80) @(negedge i_clk);
        if (errors == 0 && awaited_answers.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
